// ----- rtl/bol_pkg.sv -----
`timescale 1ns / 1ps

package bol_pkg;

  localparam int VALUE_W = 32;

  // operation codes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_RM_FRONT  = 3'd2;
  localparam logic [2:0] OP_RM_BACK   = 3'd3;
  localparam logic [2:0] OP_RM_MATCH  = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // front and back read as this when the list is empty
  localparam logic signed [VALUE_W-1:0] EMPTY_MARK = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [VALUE_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [4:0]                entry_count;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
  } rsp_item_t;

endpackage

// ----- rtl/bol_ram.sv -----
`timescale 1ns / 1ps

module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bounded_ordered_list.sv -----
`timescale 1ns / 1ps

// bounded ordered list of signed 32-bit values, up to CAPACITY entries, kept as a
// singly linked chain in two single-port-write rams (values and next links, both
// with registered read). one item is worked at a time. an insert writes the new
// entry and its link. removals walk the chain from the front one entry per cycle
// (the walk is paced by the link ram read feeding the next read address); taking
// the front then picks up the new front value, taking a later entry returns its
// slot to the free chain, taking the only entry goes straight to the result, and
// a search that finds nothing stops at the back entry. every item ends by loading
// the result register. inserts into a full list and removals from an empty list
// are reported through status and change nothing, as are unknown-op items.
// a finished result sits in an output register, so the next item is taken while
// the previous result still waits. no clearing pass is needed after reset.
module bounded_ordered_list
  import bol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // slot index width
  localparam int CW = $clog2(CAPACITY + 1);                    // count width

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;  // write the new entry and its link
  localparam logic [2:0] S_WALK = 3'd2;  // one chain entry per cycle
  localparam logic [2:0] S_FIXF = 3'd3;  // pick up the new front value
  localparam logic [2:0] S_PUSH = 3'd4;  // return the removed slot to the free chain
  localparam logic [2:0] S_FIN  = 3'd5;  // load the result register

  logic [2:0]         st;
  logic [2:0]         op_q;
  logic [VALUE_W-1:0] val_q;
  logic [1:0]         stat;

  // list bookkeeping
  logic [CW-1:0]      cnt;        // entries held
  logic [CW-1:0]      fresh;      // slots ever handed out; slots above are untouched
  logic [SW-1:0]      fhead;      // top of the free chain (freed slots, linked in ram)
  logic [SW-1:0]      front;
  logic [SW-1:0]      back;
  logic [VALUE_W-1:0] front_val;
  logic [VALUE_W-1:0] back_val;

  // walk registers
  logic [SW-1:0]      cur;
  logic [SW-1:0]      prev;
  logic [VALUE_W-1:0] prev_val;
  logic [SW-1:0]      idx;

  // ram ports
  logic [SW-1:0]      raddr;
  logic [VALUE_W-1:0] rd_entry;
  logic [SW-1:0]      rd_link;
  logic               ent_we;
  logic [SW-1:0]      ent_waddr;
  logic               lnk_we;
  logic [SW-1:0]      lnk_waddr;
  logic [SW-1:0]      lnk_wdata;

  logic               accept;
  logic               req_is_ins;
  logic               popped;     // freed slots exist, reuse the top one
  logic [SW-1:0]      new_slot;
  logic               last;       // walk sits on the back entry
  logic               hit;
  logic               rsp_load;

  assign req_stall  = (st != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign req_is_ins = (req.op == OP_INS_FRONT) || (req.op == OP_INS_BACK);

  // freed slots = fresh - cnt, so the free chain is non-empty exactly when cnt < fresh
  assign popped   = (cnt < fresh);
  assign new_slot = popped ? fhead : fresh[SW-1:0];
  assign last     = (CW'(idx) == CW'(cnt - CW'(1)));
  assign rsp_load = (st == S_FIN) && (!rsp_valid || !rsp_stall);

  always_comb begin
    case (op_q)
      OP_RM_FRONT: hit = (idx == '0);
      OP_RM_BACK:  hit = last;
      OP_RM_MATCH: hit = (rd_entry == val_q);
      default:     hit = 1'b0;
    endcase
  end

  // read address: the free chain top for inserts, the front to start a walk,
  // then whatever link just came back
  always_comb begin
    case (st)
      S_IDLE:  raddr = req_is_ins ? fhead : front;
      S_WALK:  raddr = rd_link;
      default: raddr = front;
    endcase
  end

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = new_slot;
    lnk_we    = 1'b0;
    lnk_waddr = cur;
    lnk_wdata = fhead;
    case (st)
      S_INS: begin
        ent_we = 1'b1;
        if (cnt != '0) begin
          lnk_we = 1'b1;
          if (op_q == OP_INS_FRONT) begin
            lnk_waddr = new_slot;
            lnk_wdata = front;
          end else begin
            lnk_waddr = back;
            lnk_wdata = new_slot;
          end
        end
      end
      S_WALK: begin
        if (hit) begin
          lnk_we = 1'b1;
          if ((cnt != CW'(1)) && (idx != '0)) begin
            // bridge the predecessor over the removed entry
            lnk_waddr = prev;
            lnk_wdata = rd_link;
          end
        end
      end
      S_PUSH: begin
        lnk_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  bol_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(val_q),
    .raddr(raddr),
    .rdata(rd_entry)
  );

  bol_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_link_ram (
    .clk  (clk),
    .we   (lnk_we),
    .waddr(lnk_waddr),
    .wdata(lnk_wdata),
    .raddr(raddr),
    .rdata(rd_link)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      cnt   <= '0;
      fresh <= '0;
      front <= '0;
      back  <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.op;
            val_q <= req.value;
            cur   <= front;
            prev  <= front;
            idx   <= '0;
            stat  <= ST_DONE;
            if (req_is_ins) begin
              if (cnt == CW'(CAPACITY)) begin
                stat <= ST_FULL;
                st   <= S_FIN;
              end else begin
                st <= S_INS;
              end
            end else if ((req.op == OP_RM_FRONT) || (req.op == OP_RM_BACK) ||
                         (req.op == OP_RM_MATCH)) begin
              if (cnt == '0) begin
                stat <= ST_EMPTY;
                st   <= S_FIN;
              end else begin
                st <= S_WALK;
              end
            end else begin
              // unknown op: report the list unchanged
              st <= S_FIN;
            end
          end
        end
        S_INS: begin
          if (popped) begin
            fhead <= rd_link;
          end else begin
            fresh <= fresh + CW'(1);
          end
          if (cnt == '0) begin
            front     <= new_slot;
            back      <= new_slot;
            front_val <= val_q;
            back_val  <= val_q;
          end else if (op_q == OP_INS_FRONT) begin
            front     <= new_slot;
            front_val <= val_q;
          end else begin
            back     <= new_slot;
            back_val <= val_q;
          end
          cnt <= cnt + CW'(1);
          st  <= S_FIN;
        end
        S_WALK: begin
          if (hit) begin
            cnt <= cnt - CW'(1);
            if (cnt == CW'(1)) begin
              // last entry leaves
              front <= '0;
              back  <= '0;
              fhead <= cur;
              st    <= S_FIN;
            end else if (idx == '0) begin
              // front leaves; its successor is being read now
              front <= rd_link;
              fhead <= cur;
              st    <= S_FIXF;
            end else begin
              if (last) begin
                back     <= prev;
                back_val <= prev_val;
              end
              st <= S_PUSH;
            end
          end else if (last) begin
            stat <= ST_NOT_FOUND;
            st   <= S_FIN;
          end else begin
            prev     <= cur;
            prev_val <= rd_entry;
            cur      <= rd_link;
            idx      <= idx + SW'(1);
          end
        end
        S_FIXF: begin
          front_val <= rd_entry;
          st        <= S_FIN;
        end
        S_PUSH: begin
          fhead <= cur;
          st    <= S_FIN;
        end
        S_FIN: begin
          if (rsp_load) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status      <= stat;
      rsp.entry_count <= 5'(cnt);
      rsp.is_empty    <= (cnt == '0);
      rsp.front_value <= (cnt == '0) ? EMPTY_MARK : front_val;
      rsp.back_value  <= (cnt == '0) ? EMPTY_MARK : back_val;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
  import bol_pkg::*;
();

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_SLACK = 40;
  localparam int IDLE_PCT    = 37;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  // request side, driven at the falling edge
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;

  // response side, stall driven at the falling edge
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  bounded_ordered_list #(
    .CAPACITY(LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // idle rates in percent per cycle, zeroed during the no-idle stretch
  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;

  // a test asks for a long output hold-off, the response process counts it
  bit hold_ask  = 1'b0;
  int hold_left = 0;

  int mismatch_count = 0;

  // expected list reports, oldest first
  rsp_item_t report_q[$];

  // ---------------------------------------------------------------------------
  // list predictor: slot values, next links, free flags, head and tail
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] slot_val [LIST_DEPTH];
  int                        slot_next[LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     slot_free = '1;
  int                        head_slot = 0;
  int                        tail_slot = 0;
  int                        n_held    = 0;

  // take slot cur out of the chain, prv is its predecessor when not the head
  function automatic void drop_slot(int prv, int cur);
    if (n_held == 1) begin
      head_slot = 0;
      tail_slot = 0;
    end else if (cur == head_slot) begin
      head_slot = slot_next[cur] % LIST_DEPTH;
    end else begin
      slot_next[prv] = slot_next[cur];
      if (cur == tail_slot) tail_slot = prv;
    end
    slot_free[cur] = 1'b1;
    n_held--;
  endfunction

  // apply one request to the predicted list and build the report it gives
  function automatic rsp_item_t list_apply(req_item_t it);
    rsp_item_t r;
    int        s;
    int        prv;
    int        cur;
    int        k;
    r        = '0;
    r.status = ST_DONE;
    case (it.op)
      OP_INS_FRONT, OP_INS_BACK: begin
        // lowest numbered free slot
        s = LIST_DEPTH;
        for (k = LIST_DEPTH - 1; k >= 0; k--)
          if (slot_free[k]) s = k;
        if (n_held >= LIST_DEPTH || s >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_free[s] = 1'b0;
          slot_val[s]  = it.value;
          if (n_held == 0) begin
            slot_next[s] = 0;
            head_slot    = s;
            tail_slot    = s;
          end else if (it.op == OP_INS_FRONT) begin
            slot_next[s] = head_slot;
            head_slot    = s;
          end else begin
            slot_next[s]         = 0;
            slot_next[tail_slot] = s;
            tail_slot            = s;
          end
          n_held++;
        end
      end
      OP_RM_FRONT, OP_RM_BACK, OP_RM_MATCH: begin
        if (n_held == 0) begin
          r.status = ST_EMPTY;
        end else if (it.op == OP_RM_FRONT) begin
          drop_slot(0, head_slot);
        end else if (it.op == OP_RM_BACK) begin
          // walk to the last entry, remembering its predecessor
          prv = head_slot;
          cur = head_slot;
          for (k = 1; k < n_held; k++) begin
            prv = cur;
            cur = slot_next[cur] % LIST_DEPTH;
          end
          drop_slot(prv, cur);
        end else begin
          // first equal entry seen from the front
          r.status = ST_NOT_FOUND;
          prv      = head_slot;
          cur      = head_slot;
          for (k = 0; k < n_held; k++) begin
            if (slot_val[cur] == it.value) begin
              drop_slot(prv, cur);
              r.status = ST_DONE;
              break;
            end
            prv = cur;
            cur = slot_next[cur] % LIST_DEPTH;
          end
        end
      end
      default: ;  // unknown codes leave the list alone
    endcase
    r.entry_count = 5'(n_held);
    r.is_empty    = (n_held == 0);
    r.front_value = (n_held == 0) ? EMPTY_MARK : slot_val[head_slot];
    r.back_value  = (n_held == 0) ? EMPTY_MARK : slot_val[tail_slot];
    return r;
  endfunction

  // value at position pos counted from the front of the predicted list
  function automatic logic signed [VALUE_W-1:0] entry_at(int pos);
    int cur;
    cur = head_slot;
    repeat (pos) cur = slot_next[cur] % LIST_DEPTH;
    return slot_val[cur];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // random value: small range for duplicates, extremes, or anything
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $signed(32'($urandom_range(8))) - 32'sd4;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7fff_ffff;
          1: return EMPTY_MARK;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // random request, grow_pct steers between inserts and removals
  function automatic req_item_t random_req(int grow_pct);
    req_item_t it;
    int        roll;
    it.value = pick_value();
    roll     = $urandom_range(99);
    if (roll < 4) begin
      // unknown codes above the last operation
      it.op = OP_RM_MATCH + 3'($urandom_range(1, 3));
    end else if (roll < 4 + grow_pct * 96 / 100) begin
      it.op = $urandom_range(1) ? OP_INS_BACK : OP_INS_FRONT;
    end else begin
      case ($urandom_range(2))
        0: it.op = OP_RM_FRONT;
        1: it.op = OP_RM_BACK;
        default: begin
          it.op = OP_RM_MATCH;
          // mostly search for something that is really there
          if (n_held > 0 && $urandom_range(99) < 70)
            it.value = entry_at($urandom_range(n_held - 1));
        end
      endcase
    end
    return it;
  endfunction

  // offer one item, hold it until accepted, then predict its report
  task automatic send_item(input req_item_t it);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    report_q.push_back(list_apply(it));
  endtask

  task automatic send_op(input logic [2:0] op, input logic signed [VALUE_W-1:0] value);
    req_item_t it;
    it.op    = op;
    it.value = value;
    send_item(it);
  endtask

  // stop offering and wait until every report is back
  task automatic pause_until_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // removals and an unknown code on the empty list
  task automatic test_empty_list();
    send_op(OP_RM_FRONT, 32'sd0);
    send_op(OP_RM_BACK, 32'sd0);
    send_op(OP_RM_MATCH, EMPTY_MARK);
    send_op(OP_RM_MATCH + 3'd3, -32'sd1);
  endtask

  // fill from both ends with extreme values, then overflow both ways
  task automatic test_fill_to_capacity();
    logic signed [VALUE_W-1:0] fill_vals[LIST_DEPTH] = '{
      32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1,
      32'sd5, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1,
      32'sh8000_0001, 32'sh7fff_fffe, 32'sd5, 32'sh1234_5678,
      -32'sd2, 32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sd7};
    int i;
    for (i = 0; i < LIST_DEPTH; i++)
      send_op((i % 2) ? OP_INS_BACK : OP_INS_FRONT, fill_vals[i]);
    send_op(OP_INS_FRONT, 32'sd99);
    send_op(OP_INS_BACK, 32'sd98);
    // unknown code on a full list reports it unchanged
    send_op(OP_RM_MATCH + 3'd1, 32'sd0);
  endtask

  // each removal path on a populated list
  task automatic test_removals();
    send_op(OP_RM_MATCH, 32'sd12345);       // nothing equal
    send_op(OP_RM_MATCH, 32'sd5);           // duplicate, first from front goes
    send_op(OP_RM_BACK, 32'sd0);
    send_op(OP_RM_MATCH, entry_at(n_held - 1));  // match on the tail
    send_op(OP_RM_MATCH, entry_at(0));           // match on the head
    send_op(OP_RM_FRONT, 32'sd0);
  endtask

  // random traffic, alternating growth and shrink bursts to hit full and empty
  task automatic test_random_traffic(input int items);
    int i;
    int grow_pct;
    grow_pct = 75;
    for (i = 0; i < items; i++) begin
      if (i % 50 == 0) grow_pct = (grow_pct == 75) ? 25 : 75;
      send_item(random_req(grow_pct));
    end
  endtask

  // back to back traffic with no idling on either side
  task automatic test_no_idle_stretch(input int items);
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < items; i++) send_item(random_req((i / 40) % 2 ? 30 : 70));
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
  endtask

  // long output hold-off while the sender keeps offering, input must stall
  task automatic test_output_hold(input int items);
    int i;
    hold_ask = 1'b1;
    for (i = 0; i < items; i++) send_item(random_req(50));
  endtask

  // ---------------------------------------------------------------------------
  // response side: random stall plus the long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // report checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s: expected %08h, actual %08h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (report_q.size() == 0) begin
        mismatch_count++;
        $error("report with no item outstanding: %p", rsp);
      end else begin
        want = report_q.pop_front();
        check_field("status", 32'(want.status), 32'(rsp.status));
        check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
        check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
        check_field("front_value", want.front_value, rsp.front_value);
        check_field("back_value", want.back_value, rsp.back_value);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    test_empty_list();
    test_fill_to_capacity();
    test_removals();
    pause_until_drained();

    // random
    test_random_traffic(700);
    pause_until_drained();
    test_no_idle_stretch(300);
    test_output_hold(60);
    test_random_traffic(500);

    // let everything come back
    @(negedge clk);
    req_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);

    if (mismatch_count == 0 && report_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
